// File: rtl/tect_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tect_pkg
// Shared types and codes for the term equivalence cluster table.
// ----------------------------------------------------------------------------
package tect_pkg;

    localparam int TERM_W  = 8;
    localparam int LABEL_W = TERM_W + 1;

    typedef logic [TERM_W-1:0]  term_t;
    typedef logic [LABEL_W-1:0] label_t;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DECIDE,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        UPD_FRESH,
        UPD_JOIN_B,
        UPD_JOIN_A,
        UPD_RELABEL
    } upd_t;

    // Controls from the sequencer to the ring of cells
    typedef struct packed {
        logic   shift;
        label_t wb;
    } ring_ctl_t;

endpackage

// File: rtl/tect_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tect_cell
// One ring cell: holds the cluster label of one term and passes it on.
// ----------------------------------------------------------------------------
module tect_cell
    import tect_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   shift,
    input  label_t din,
    output label_t q
);

    label_t label_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            label_reg <= '0;
        end
        else if (shift)
        begin
            label_reg <= din;
        end
    end

    assign q = label_reg;

endmodule

// File: rtl/tect_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tect_ctrl
// Sequencer: looks up both terms as the ring turns, then rewrites entries
// at the head of the ring on a second turn when the table must change.
// ----------------------------------------------------------------------------
module tect_ctrl
    import tect_pkg::*;
#(
    parameter int TERMS = 256
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      kind,
    input  term_t     term_a,
    input  term_t     term_b,
    input  label_t    head,
    output ring_ctl_t ring,
    output logic      busy,
    output logic      done,
    output logic      same_cluster,
    output logic      merged
);

    localparam int IDX_W = $clog2(TERMS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TERMS - 1);

    state_t           state_reg, state_next;
    upd_t             mode_reg, mode_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             kind_reg, kind_next;
    term_t            ta_reg, ta_next;
    term_t            tb_reg, tb_next;
    logic             ok_reg, ok_next;
    label_t           la_reg, la_next;
    label_t           lb_reg, lb_next;
    logic             same_reg, same_next;
    logic             merged_reg, merged_next;

    logic             hit_a;
    logic             hit_b;
    logic             last;
    label_t           fresh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        kind_reg   <= kind_next;
        ta_reg     <= ta_next;
        tb_reg     <= tb_next;
        ok_reg     <= ok_next;
        la_reg     <= la_next;
        lb_reg     <= lb_next;
        same_reg   <= same_next;
        merged_reg <= merged_next;
    end

    assign hit_a = (32'(idx_reg) == 32'(ta_reg));
    assign hit_b = (32'(idx_reg) == 32'(tb_reg));
    assign last  = (idx_reg == IDX_LAST);
    assign fresh = label_t'(ta_reg) + label_t'(1);

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        kind_next   = kind_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        ok_next     = ok_reg;
        la_next     = la_reg;
        lb_next     = lb_reg;
        same_next   = same_reg;
        merged_next = merged_reg;
        ring.shift  = 1'b0;
        ring.wb     = head;
        done        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next  = kind;
                    ta_next    = term_a;
                    tb_next    = term_b;
                    ok_next    = (32'(term_a) < TERMS) && (32'(term_b) < TERMS);
                    la_next    = '0;
                    lb_next    = '0;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                ring.shift = 1'b1;
                if (hit_a)
                begin
                    la_next = head;
                end
                if (hit_b)
                begin
                    lb_next = head;
                end
                if (last)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                merged_next = 1'b0;
                if (kind_reg == KIND_QUERY)
                begin
                    same_next  = (la_reg != '0) && (la_reg == lb_reg);
                    state_next = ST_DONE;
                end
                else
                begin
                    same_next  = ok_reg;
                    state_next = ST_DONE;
                    if (ok_reg)
                    begin
                        priority if (la_reg == '0 && lb_reg == '0)
                        begin
                            mode_next  = UPD_FRESH;
                            state_next = ST_UPDATE;
                        end
                        else if (lb_reg == '0)
                        begin
                            mode_next  = UPD_JOIN_B;
                            state_next = ST_UPDATE;
                        end
                        else if (la_reg == '0)
                        begin
                            mode_next  = UPD_JOIN_A;
                            state_next = ST_UPDATE;
                        end
                        else if (la_reg != lb_reg)
                        begin
                            mode_next   = UPD_RELABEL;
                            merged_next = 1'b1;
                            state_next  = ST_UPDATE;
                        end
                        else
                        begin
                            // Both already in one cluster: leave the table alone
                            state_next = ST_DONE;
                        end
                    end
                end
            end
            ST_UPDATE:
            begin
                ring.shift = 1'b1;
                unique case (mode_reg)
                    UPD_FRESH:
                    begin
                        if (hit_a || hit_b)
                        begin
                            ring.wb = fresh;
                        end
                    end
                    UPD_JOIN_B:
                    begin
                        if (hit_b)
                        begin
                            ring.wb = la_reg;
                        end
                    end
                    UPD_JOIN_A:
                    begin
                        if (hit_a)
                        begin
                            ring.wb = lb_reg;
                        end
                    end
                    UPD_RELABEL:
                    begin
                        if (head == lb_reg)
                        begin
                            ring.wb = la_reg;
                        end
                    end
                    default:
                    begin
                        ring.wb = head;
                    end
                endcase
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance the head index with the ring; wrap after the last term
        if (ring.shift)
        begin
            idx_next = last ? '0 : idx_reg + IDX_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign same_cluster = same_reg;
    assign merged       = merged_reg;

endmodule

// File: rtl/term_equivalence_cluster_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// term_equivalence_cluster_table_top
// Quick-find equivalence table over term indices, built as a ring of cells.
// ----------------------------------------------------------------------------
// Issue a word by raising start while busy is low; kind, term_a and term_b
// are sampled at that edge. Exactly one result word follows, shown for one
// cycle with done high; the receiver cannot stall it, so capture it then.
// Timing is set by the ring of TERMS label cells, which turns one position
// per cycle during a lookup or rewrite turn, past a single head where all
// lookups and rewrites happen: a query, or an add that changes nothing or
// names a term at or above TERMS, raises done after one full turn and a
// decide step; an add that changes the table takes one more full turn
// before done. busy drops the cycle after done, and a new word is taken
// only once busy is low again. Reset clears all labels at once.
// ----------------------------------------------------------------------------
module term_equivalence_cluster_table_top
    import tect_pkg::*;
#(
    parameter int TERMS = 256
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  logic  kind,
    input  term_t term_a,
    input  term_t term_b,
    output logic  busy,
    output logic  done,
    output logic  same_cluster,
    output logic  merged
);

    ring_ctl_t ring;
    label_t    cell_q [TERMS];

    // Sequencer: watches the head cell, feeds the tail cell
    tect_ctrl #(
        .TERMS (TERMS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .term_a       (term_a),
        .term_b       (term_b),
        .head         (cell_q[0]),
        .ring         (ring),
        .busy         (busy),
        .done         (done),
        .same_cluster (same_cluster),
        .merged       (merged)
    );

    // Ring of label cells: each cell takes its upper neighbor's label, the
    // last cell takes the rewritten head label.
    for (genvar k = 0; k < TERMS; k++)
    begin : g_cell
        label_t din;

        if (k == TERMS - 1)
        begin : g_tail
            assign din = ring.wb;
        end
        else
        begin : g_mid
            assign din = cell_q[k + 1];
        end

        tect_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (ring.shift),
            .din   (din),
            .q     (cell_q[k])
        );
    end

endmodule
